// ===== design/edpq_pkg.sv =====
package edpq_pkg;

    // Sizes of the stores.
    localparam int MAX_WIDTH     = 2048;
    localparam int PALETTE_DEPTH = 256;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WID_W  = COL_W + 1;
    localparam int PAL_AW = $clog2(PALETTE_DEPTH);

    // Register widths.
    localparam int IMG_WIDTH_W  = 12;
    localparam int IMG_HEIGHT_W = 13;
    localparam int PAL_COUNT_W  = 9;
    localparam int CFG_DATA_W   = 13;
    localparam int ROW_W        = IMG_HEIGHT_W;

    // Register reset values.
    localparam logic [IMG_WIDTH_W-1:0]  IMG_WIDTH_RESET  = 12'd640;
    localparam logic [IMG_HEIGHT_W-1:0] IMG_HEIGHT_RESET = 13'd480;
    localparam logic [PAL_COUNT_W-1:0]  PAL_COUNT_RESET  = 9'd256;
    localparam logic                    DIFFUSION_RESET  = 1'b1;

    // Arithmetic widths.
    localparam int SQ_W   = 18;
    localparam int DIST_W = 20;

    typedef enum logic [1:0] {
        CFG_IMAGE_WIDTH      = 2'd0,
        CFG_IMAGE_HEIGHT     = 2'd1,
        CFG_PALETTE_COUNT    = 2'd2,
        CFG_DIFFUSION_ENABLE = 2'd3
    } cfg_index_t;

    localparam logic OP_PALETTE = 1'b0;
    localparam logic OP_PIXEL   = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] entry_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic [7:0] chosen_index;
    } out_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb8_t;

    // Diffused channel value, saturated to -256..511.
    typedef logic signed [9:0] chan_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } val3_t;

    // Diffused error of one channel.
    typedef logic signed [10:0] err_t;

    typedef struct packed {
        err_t red;
        err_t green;
        err_t blue;
    } err3_t;

    typedef struct packed {
        logic [WID_W-1:0]        width;
        logic [IMG_HEIGHT_W-1:0] height;
        logic                    diffusion;
    } geom_t;

    typedef struct packed {
        logic fetch;
        logic latch;
        logic commit;
        logic restart;
    } diff_ctl_t;

    typedef struct packed {
        logic              en;
        logic [PAL_AW-1:0] addr;
        rgb8_t             rgb;
    } pal_wr_t;

    typedef struct packed {
        logic              done;
        logic [PAL_AW-1:0] index;
        rgb8_t             rgb;
    } search_res_t;

    // Pixel plus carried and line errors, saturated.
    function automatic chan_t diffuse_chan(logic [7:0] p, err_t carry, err_t above);
        logic signed [11:0] s;
        s = $signed({4'b0000, p}) + 12'(carry) + 12'(above);
        if (s < -12'sd256) begin
            return -10'sd256;
        end
        if (s > 12'sd511) begin
            return 10'sd511;
        end
        return s[9:0];
    endfunction

    // Squared difference between a diffused value and a palette channel.
    function automatic logic [SQ_W-1:0] sq_diff(chan_t v, logic [7:0] p);
        logic signed [10:0] d;
        logic signed [21:0] m;
        d = 11'(v) - $signed({3'b000, p});
        m = d * d;
        return SQ_W'(m);
    endfunction

    // Error of one channel against the chosen entry.
    function automatic err_t chan_error(chan_t v, logic [7:0] p, logic en);
        err_t e;
        e = 11'(v) - $signed({3'b000, p});
        return en ? e : '0;
    endfunction

    // Product of the error and a small weight, divided by eight toward zero.
    function automatic err_t eighths(err_t e, logic [1:0] w);
        logic signed [12:0] m;
        logic signed [12:0] b;
        m = 13'(e) * $signed({11'b0, w});
        b = m[12] ? m + 13'sd7 : m;
        return 11'(b >>> 3);
    endfunction

endpackage

// ===== design/edpq_ram.sv =====
module edpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/edpq_search.sv =====
module edpq_search import edpq_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  pal_wr_t           pal_wr,
    input  logic              start,
    input  logic [PAL_AW-1:0] last_index,
    input  val3_t             val,
    output search_res_t       res
);

    // Read stage.
    logic              run_reg,      run_next;
    logic [PAL_AW-1:0] idx_reg,      idx_next;
    logic              rd_valid_reg;
    logic              rd_last_reg;
    logic [PAL_AW-1:0] rd_idx_reg;
    rgb8_t             rd_rgb;

    // Square stage.
    logic              sq_valid_reg;
    logic              sq_last_reg;
    logic [PAL_AW-1:0] sq_idx_reg;
    rgb8_t             sq_rgb_reg;
    logic [SQ_W-1:0]   sq_r_reg, sq_g_reg, sq_b_reg;

    // Compare stage.
    logic [DIST_W-1:0] cand_dist;
    logic              take;
    logic              done_reg;
    logic [DIST_W-1:0] best_dist_reg;
    logic [PAL_AW-1:0] best_idx_reg;
    rgb8_t             best_rgb_reg;

    edpq_ram #(
        .WIDTH ($bits(rgb8_t)),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk     (clk),
        .wr_en   (pal_wr.en),
        .wr_addr (pal_wr.addr),
        .wr_data (pal_wr.rgb),
        .rd_en   (run_reg),
        .rd_addr (idx_reg),
        .rd_data (rd_rgb)
    );

    always_comb
    begin
        run_next = run_reg;
        idx_next = idx_reg;
        if (start)
        begin
            run_next = 1'b1;
            idx_next = '0;
        end
        else if (run_reg)
        begin
            if (idx_reg == last_index)
            begin
                run_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + PAL_AW'(1);
            end
        end
    end

    assign cand_dist = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);
    assign take = sq_valid_reg && ((sq_idx_reg == '0) || (cand_dist < best_dist_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg      <= 1'b0;
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
            rd_last_reg  <= 1'b0;
            sq_valid_reg <= 1'b0;
            sq_last_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            run_reg      <= run_next;
            idx_reg      <= idx_next;
            rd_valid_reg <= run_reg;
            rd_last_reg  <= run_reg && (idx_reg == last_index);
            sq_valid_reg <= rd_valid_reg;
            sq_last_reg  <= rd_valid_reg && rd_last_reg;
            done_reg     <= sq_valid_reg && sq_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= idx_reg;
        sq_idx_reg <= rd_idx_reg;
        sq_rgb_reg <= rd_rgb;
        sq_r_reg   <= sq_diff(val.red,   rd_rgb.red);
        sq_g_reg   <= sq_diff(val.green, rd_rgb.green);
        sq_b_reg   <= sq_diff(val.blue,  rd_rgb.blue);
        if (take)
        begin
            best_dist_reg <= cand_dist;
            best_idx_reg  <= sq_idx_reg;
            best_rgb_reg  <= sq_rgb_reg;
        end
    end

    assign res.done  = done_reg;
    assign res.index = best_idx_reg;
    assign res.rgb   = best_rgb_reg;

endmodule

// ===== design/edpq_diffuse.sv =====
module edpq_diffuse import edpq_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  geom_t     geom,
    input  diff_ctl_t ctl,
    input  rgb8_t     pix,
    input  rgb8_t     chosen,
    output val3_t     val
);

    logic [COL_W-1:0] col_reg,   col_next;
    logic [ROW_W-1:0] row_reg,   row_next;
    err3_t            right_reg, right_next;
    err3_t            diag_reg,  diag_next;
    val3_t            val_reg,   val_next;

    err3_t            above_raw;
    err3_t            above;
    err3_t            err;
    err3_t            three;
    err3_t            two;
    err3_t            store_word;
    logic             last_col;

    edpq_ram #(
        .WIDTH ($bits(err3_t)),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .clk     (clk),
        .wr_en   (ctl.commit),
        .wr_addr (col_reg),
        .wr_data (store_word),
        .rd_en   (ctl.fetch),
        .rd_addr (col_reg),
        .rd_data (above_raw)
    );

    // The line store holds nothing useful on the first row of a frame.
    assign above = (row_reg == '0) ? '0 : above_raw;

    always_comb
    begin
        if (geom.diffusion)
        begin
            val_next.red   = diffuse_chan(pix.red,   right_reg.red,   above.red);
            val_next.green = diffuse_chan(pix.green, right_reg.green, above.green);
            val_next.blue  = diffuse_chan(pix.blue,  right_reg.blue,  above.blue);
        end
        else
        begin
            val_next.red   = $signed({2'b00, pix.red});
            val_next.green = $signed({2'b00, pix.green});
            val_next.blue  = $signed({2'b00, pix.blue});
        end
    end

    always_comb
    begin
        err.red    = chan_error(val_reg.red,   chosen.red,   geom.diffusion);
        err.green  = chan_error(val_reg.green, chosen.green, geom.diffusion);
        err.blue   = chan_error(val_reg.blue,  chosen.blue,  geom.diffusion);
        three.red   = eighths(err.red,   2'd3);
        three.green = eighths(err.green, 2'd3);
        three.blue  = eighths(err.blue,  2'd3);
        two.red     = eighths(err.red,   2'd2);
        two.green   = eighths(err.green, 2'd2);
        two.blue    = eighths(err.blue,  2'd2);
        store_word.red   = three.red   + diag_reg.red;
        store_word.green = three.green + diag_reg.green;
        store_word.blue  = three.blue  + diag_reg.blue;
    end

    assign last_col = (WID_W'(col_reg) + WID_W'(1)) >= geom.width;

    always_comb
    begin
        col_next   = col_reg + COL_W'(1);
        row_next   = row_reg;
        right_next = three;
        diag_next  = two;
        if (last_col)
        begin
            col_next   = '0;
            right_next = '0;
            diag_next  = '0;
            row_next   = ((row_reg + ROW_W'(1)) >= geom.height) ? '0 : row_reg + ROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            right_reg <= '0;
            diag_reg  <= '0;
        end
        else if (ctl.restart)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            right_reg <= '0;
            diag_reg  <= '0;
        end
        else if (ctl.commit)
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            right_reg <= right_next;
            diag_reg  <= diag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            val_reg <= val_next;
        end
    end

    assign val = val_reg;

endmodule

// ===== design/error_diffusion_palette_quantizer_unit.sv =====
// Channel  Handshake          Beat
// pix      pix_valid/stall    in_item_t: palette write (op 0) or pixel (op 1)
// res      res_valid/stall    out_item_t: chosen entry color, alpha and index
// cfg      cfg_valid/ready    cfg_index selects the register, cfg_data the value
//
// A palette write beat never stalls the input. A pixel's result is committed after
// the line store is read, each palette entry is read through the single palette
// memory read port, the distance pipeline drains and the commit waits for a free
// output slot. The next beat is taken in the cycle after the commit, so a pixel is
// never taken while another is in work. Reset clears the control state, the counters
// and the carries; both memories need no clearing. A finished result waits in the
// output register while the next beat is taken; only a second result stalls the
// block on a held res_stall.
module error_diffusion_palette_quantizer_unit import edpq_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pix_valid,
    output logic                  pix_stall,
    input  in_item_t              pix_data,
    output logic                  res_valid,
    input  logic                  res_stall,
    output out_item_t             res_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // The sequencer walks each pixel through fetch, search and commit.
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_FETCH  = 4'b0010,
        ST_SEARCH = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [IMG_WIDTH_W-1:0]  width_reg;
    logic [IMG_HEIGHT_W-1:0] height_reg;
    logic [PAL_COUNT_W-1:0]  count_reg;
    logic                    diffusion_reg;

    rgb8_t      pix_rgb_reg;
    logic [7:0] pix_alpha_reg;

    logic       res_valid_reg, res_valid_next;
    out_item_t  res_data_reg;

    logic              accept;
    logic              cfg_write;
    logic              slot_free;
    logic              commit;
    geom_t             geom;
    logic [PAL_AW-1:0] last_index;
    pal_wr_t           pal_wr;
    diff_ctl_t         dctl;
    search_res_t       sres;
    val3_t             val;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Configuration registers. A geometry write restarts the frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= IMG_WIDTH_RESET;
            height_reg    <= IMG_HEIGHT_RESET;
            count_reg     <= PAL_COUNT_RESET;
            diffusion_reg <= DIFFUSION_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:      width_reg     <= cfg_data[IMG_WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT:     height_reg    <= cfg_data[IMG_HEIGHT_W-1:0];
                CFG_PALETTE_COUNT:    count_reg     <= cfg_data[PAL_COUNT_W-1:0];
                CFG_DIFFUSION_ENABLE: diffusion_reg <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    // Registers are used clamped: width to 1..MAX_WIDTH, height to at least one,
    // and the palette count to 1..PALETTE_DEPTH.
    always_comb
    begin
        if (width_reg == '0)
        begin
            geom.width = WID_W'(1);
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            geom.width = WID_W'(MAX_WIDTH);
        end
        else
        begin
            geom.width = WID_W'(width_reg);
        end
        geom.height    = (height_reg == '0) ? IMG_HEIGHT_W'(1) : height_reg;
        geom.diffusion = diffusion_reg;

        if (count_reg == '0)
        begin
            last_index = '0;
        end
        else if (int'(count_reg) > PALETTE_DEPTH)
        begin
            last_index = PAL_AW'(PALETTE_DEPTH - 1);
        end
        else
        begin
            last_index = PAL_AW'(count_reg - PAL_COUNT_W'(1));
        end
    end

    assign pix_stall = (state_reg != ST_IDLE);
    assign accept    = pix_valid && !pix_stall;
    assign slot_free = !res_valid_reg || !res_stall;
    assign commit    = (state_reg == ST_FINISH) && slot_free;

    // Palette writes go straight into the palette memory; an index beyond the
    // memory is dropped.
    assign pal_wr.en   = accept && (pix_data.op == OP_PALETTE)
                         && ({1'b0, pix_data.entry_index} < 9'(PALETTE_DEPTH));
    assign pal_wr.addr = PAL_AW'(pix_data.entry_index);
    assign pal_wr.rgb  = '{red: pix_data.red, green: pix_data.green, blue: pix_data.blue};

    // The line store is read as the pixel is taken, the diffused value is
    // latched in the next cycle together with the start of the search.
    assign dctl.fetch   = accept && (pix_data.op == OP_PIXEL);
    assign dctl.latch   = (state_reg == ST_FETCH);
    assign dctl.commit  = commit;
    assign dctl.restart = cfg_write
                          && ((cfg_index == CFG_IMAGE_WIDTH) || (cfg_index == CFG_IMAGE_HEIGHT));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (pix_data.op == OP_PIXEL))
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (sres.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (commit)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dctl.fetch)
        begin
            pix_rgb_reg   <= '{red: pix_data.red, green: pix_data.green, blue: pix_data.blue};
            pix_alpha_reg <= pix_data.alpha;
        end
        if (commit)
        begin
            res_data_reg.out_red      <= sres.rgb.red;
            res_data_reg.out_green    <= sres.rgb.green;
            res_data_reg.out_blue     <= sres.rgb.blue;
            res_data_reg.out_alpha    <= pix_alpha_reg;
            res_data_reg.chosen_index <= 8'(sres.index);
        end
    end

    edpq_search u_search (
        .clk        (clk),
        .rst_n      (rst_n),
        .pal_wr     (pal_wr),
        .start      (state_reg == ST_FETCH),
        .last_index (last_index),
        .val        (val),
        .res        (sres)
    );

    edpq_diffuse u_diffuse (
        .clk    (clk),
        .rst_n  (rst_n),
        .geom   (geom),
        .ctl    (dctl),
        .pix    (pix_rgb_reg),
        .chosen (sres.rgb),
        .val    (val)
    );

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

// ===== design/edpq_checker.sv =====
module edpq_checker import edpq_pkg::*; (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  pix_valid,
    input logic                  pix_stall,
    input in_item_t              pix_data,
    input logic                  res_valid,
    input logic                  res_stall,
    input out_item_t             res_data,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input cfg_index_t            cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    logic pix_beat;
    logic pal_beat;

    assign pix_beat = pix_valid && !pix_stall && (pix_data.op == OP_PIXEL);
    assign pal_beat = pix_valid && !pix_stall && (pix_data.op == OP_PALETTE);

    // A held result keeps its contents.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    // Palette writes never stall the input.
    a_pal_single: assert property (@(posedge clk) disable iff (!rst_n)
        pal_beat |=> !pix_stall)
        else $error("palette write held the input");

    // Only one pixel is in work at a time.
    a_pix_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pix_beat |=> pix_stall)
        else $error("second pixel taken while one was in work");

    // No result appears early after a pixel is taken.
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        pix_beat |=> !$rose(res_valid) ##1 !$rose(res_valid))
        else $error("result came too early");

    // Configuration beats are never refused and carry known values.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready && !$isunknown({cfg_index, cfg_data}))
        else $error("configuration beat refused or unknown");

endmodule

bind error_diffusion_palette_quantizer_unit edpq_checker u_checker (.*);

// ===== bench/error_diffusion_palette_quantizer_unit_tb.sv =====
`default_nettype none

module error_diffusion_palette_quantizer_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import edpq_pkg::*;

    // Share of cycles in which the sender holds back a beat or the receiver stalls.
    localparam int IDLE_PCT = 22;

    // Quiet cycles waited after the last result; they guarantee the block
    // has gone idle.
    localparam int DRAIN_CYCLES = PALETTE_DEPTH + 16;

    // Beats in the random part, and the hard stop for a hung run.
    localparam int RANDOM_BEATS = 1450;
    localparam int RUN_LIMIT_NS = 10_000_000;

    localparam logic [CFG_DATA_W-1:0] NO_VALUE  = '0;
    localparam out_item_t             NO_RESULT = '0;

    // One row of the directed sequence.
    typedef enum logic [1:0] {
        STEP_REG,    // register write, issued only while the block is idle
        STEP_BEAT,   // beat whose result, if any, comes from the predictor
        STEP_KNOWN   // pixel beat whose result is written out in the row
    } step_kind_t;

    typedef struct packed {
        step_kind_t            kind;
        cfg_index_t            sel;
        logic [CFG_DATA_W-1:0] value;
        in_item_t              beat;
        out_item_t             known;
    } plan_step_t;

    localparam int DIRECTED_STEPS = 28;

    // The palette is preloaded as a gray ramp, entry i = (i, i, i), so a gray pixel
    // lands exactly on its own entry and leaves no error behind.
    localparam plan_step_t DIRECTED_PLAN [DIRECTED_STEPS] = '{
        // Reset settings: 640 x 480 frame, all 256 entries searched, diffusion on.
        '{STEP_KNOWN, CFG_IMAGE_WIDTH, NO_VALUE,
          '{OP_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00},
          '{8'd0, 8'd0, 8'd0, 8'h00, 8'd0}},
        '{STEP_KNOWN, CFG_IMAGE_WIDTH, NO_VALUE,
          '{OP_PIXEL, 8'd0, 8'd255, 8'd255, 8'd255, 8'hFF},
          '{8'd255, 8'd255, 8'd255, 8'hFF, 8'd255}},
        '{STEP_KNOWN, CFG_IMAGE_WIDTH, NO_VALUE,
          '{OP_PIXEL, 8'd0, 8'd128, 8'd128, 8'd128, 8'hA5},
          '{8'd128, 8'd128, 8'd128, 8'hA5, 8'd128}},
        // Colored pixels start diffusing real error along the first row.
        '{STEP_BEAT, CFG_IMAGE_WIDTH, NO_VALUE,
          '{OP_PIXEL, 8'd0, 8'd200, 8'd10, 8'd90, 8'h5A}, NO_RESULT},
        '{STEP_BEAT, CFG_IMAGE_WIDTH, NO_VALUE,
          '{OP_PIXEL, 8'd0, 8'd17, 8'd240, 8'd3, 8'hC3}, NO_RESULT},
        // Plain nearest color: (10, 20, 30) is closest to the gray at 20.
        '{STEP_REG, CFG_DIFFUSION_ENABLE, 13'd0,
          '{OP_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00}, NO_RESULT},
        '{STEP_KNOWN, CFG_IMAGE_WIDTH, NO_VALUE,
          '{OP_PIXEL, 8'd0, 8'd10, 8'd20, 8'd30, 8'h0F},
          '{8'd20, 8'd20, 8'd20, 8'h0F, 8'd20}},
        // Entry 3 becomes a copy of entry 100; the tie must go to the lower index.
        '{STEP_BEAT, CFG_IMAGE_WIDTH, NO_VALUE,
          '{OP_PALETTE, 8'd3, 8'd100, 8'd100, 8'd100, 8'h00}, NO_RESULT},
        '{STEP_KNOWN, CFG_IMAGE_WIDTH, NO_VALUE,
          '{OP_PIXEL, 8'd0, 8'd100, 8'd100, 8'd100, 8'hF0},
          '{8'd100, 8'd100, 8'd100, 8'hF0, 8'd3}},
        '{STEP_KNOWN, CFG_IMAGE_WIDTH, NO_VALUE,
          '{OP_PIXEL, 8'd0, 8'd255, 8'd0, 8'd255, 8'h3C},
          '{8'd170, 8'd170, 8'd170, 8'h3C, 8'd170}},
        // A palette count of zero is taken as one, so only black can be chosen.
        '{STEP_REG, CFG_PALETTE_COUNT, 13'd0,
          '{OP_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00}, NO_RESULT},
        '{STEP_KNOWN, CFG_IMAGE_WIDTH, NO_VALUE,
          '{OP_PIXEL, 8'd0, 8'd255, 8'd255, 8'd255, 8'h81},
          '{8'd0, 8'd0, 8'd0, 8'h81, 8'd0}},
        // Tiny 3 x 2 frame with diffusion on and a one-entry palette: the error
        // piles up and saturates, the row wraps and the frame wraps.
        '{STEP_REG, CFG_DIFFUSION_ENABLE, 13'd1,
          '{OP_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00}, NO_RESULT},
        '{STEP_REG, CFG_IMAGE_WIDTH, 13'd3,
          '{OP_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00}, NO_RESULT},
        '{STEP_REG, CFG_IMAGE_HEIGHT, 13'd2,
          '{OP_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00}, NO_RESULT},
        '{STEP_KNOWN, CFG_IMAGE_WIDTH, NO_VALUE,
          '{OP_PIXEL, 8'd0, 8'd255, 8'd255, 8'd255, 8'h11},
          '{8'd0, 8'd0, 8'd0, 8'h11, 8'd0}},
        '{STEP_KNOWN, CFG_IMAGE_WIDTH, NO_VALUE,
          '{OP_PIXEL, 8'd0, 8'd255, 8'd255, 8'd255, 8'h22},
          '{8'd0, 8'd0, 8'd0, 8'h22, 8'd0}},
        '{STEP_KNOWN, CFG_IMAGE_WIDTH, NO_VALUE,
          '{OP_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'h33},
          '{8'd0, 8'd0, 8'd0, 8'h33, 8'd0}},
        '{STEP_KNOWN, CFG_IMAGE_WIDTH, NO_VALUE,
          '{OP_PIXEL, 8'd0, 8'd255, 8'd255, 8'd255, 8'h44},
          '{8'd0, 8'd0, 8'd0, 8'h44, 8'd0}},
        '{STEP_KNOWN, CFG_IMAGE_WIDTH, NO_VALUE,
          '{OP_PIXEL, 8'd0, 8'd255, 8'd255, 8'd255, 8'h55},
          '{8'd0, 8'd0, 8'd0, 8'h55, 8'd0}},
        '{STEP_KNOWN, CFG_IMAGE_WIDTH, NO_VALUE,
          '{OP_PIXEL, 8'd0, 8'd255, 8'd255, 8'd255, 8'h66},
          '{8'd0, 8'd0, 8'd0, 8'h66, 8'd0}},
        '{STEP_KNOWN, CFG_IMAGE_WIDTH, NO_VALUE,
          '{OP_PIXEL, 8'd0, 8'd128, 8'd64, 8'd32, 8'h77},
          '{8'd0, 8'd0, 8'd0, 8'h77, 8'd0}},
        // Out-of-range registers: 511 entries means all of them, width zero means
        // one pixel per row, so every pixel is also the last column.
        '{STEP_REG, CFG_PALETTE_COUNT, 13'd511,
          '{OP_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00}, NO_RESULT},
        '{STEP_REG, CFG_IMAGE_WIDTH, 13'd0,
          '{OP_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00}, NO_RESULT},
        '{STEP_BEAT, CFG_IMAGE_WIDTH, NO_VALUE,
          '{OP_PIXEL, 8'd0, 8'd255, 8'd0, 8'd128, 8'h7E}, NO_RESULT},
        '{STEP_BEAT, CFG_IMAGE_WIDTH, NO_VALUE,
          '{OP_PIXEL, 8'd0, 8'd1, 8'd254, 8'd127, 8'h01}, NO_RESULT},
        // Height zero means one row, so every row is the first of its frame.
        '{STEP_REG, CFG_IMAGE_HEIGHT, 13'd0,
          '{OP_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00}, NO_RESULT},
        '{STEP_BEAT, CFG_IMAGE_WIDTH, NO_VALUE,
          '{OP_PIXEL, 8'd0, 8'd0, 8'd255, 8'd0, 8'hFF}, NO_RESULT}
    };

    // Ports of the block. Every input starts at a known value.
    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  pix_valid = 1'b0;
    logic                  pix_stall;
    in_item_t              pix_data  = '0;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    out_item_t             res_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_index_t            cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // When set, neither side idles; used for one long stretch at full rate.
    bit steady_flow = 1'b0;

    // Shadow of the block's registers and state, kept by the predictor.
    logic [IMG_WIDTH_W-1:0]  shadow_width   = IMG_WIDTH_RESET;
    logic [IMG_HEIGHT_W-1:0] shadow_height  = IMG_HEIGHT_RESET;
    logic [PAL_COUNT_W-1:0]  shadow_count   = PAL_COUNT_RESET;
    logic                    shadow_diffuse = DIFFUSION_RESET;
    logic [7:0]              entry_rgb  [PALETTE_DEPTH][3];
    err_t                    line_err   [MAX_WIDTH][3];
    err_t                    carry_right[3];
    err_t                    carry_diag [3];
    int                      col_pos;
    int                      row_pos;

    // Quantized pixels that the block still owes, oldest first.
    out_item_t quantized_due[$];
    int        mismatch_count = 0;
    int        beats_sent     = 0;

    error_diffusion_palette_quantizer_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block hangs or drops a result.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    // Geometry writes start a new frame: counters and both carries go to zero.
    function automatic void restart_frame();
        int k;
        col_pos = 0;
        row_pos = 0;
        for (k = 0; k < 3; k++)
        begin
            carry_right[k] = '0;
            carry_diag[k]  = '0;
        end
    endfunction

    // Maps one pixel to its palette entry and advances the diffusion state.
    function automatic out_item_t quantize_pixel(in_item_t pix);
        int        w;
        int        h;
        int        n;
        int        col;
        int        best;
        int        best_dist;
        int        pix_dist;
        int        i;
        int        k;
        int        d;
        int        e;
        int        three;
        int        two;
        int        raw[3];
        int        val[3];
        bit        last_col;
        out_item_t res;

        // Registers outside their legal range are clamped before use.
        w = (shadow_width == 0) ? 1 : ((shadow_width > MAX_WIDTH) ? MAX_WIDTH : shadow_width);
        h = (shadow_height == 0) ? 1 : shadow_height;
        n = (shadow_count == 0) ? 1 :
            ((shadow_count > PALETTE_DEPTH) ? PALETTE_DEPTH : shadow_count);
        col = col_pos % MAX_WIDTH;
        last_col = (col + 1 >= w);

        raw[0] = pix.red;
        raw[1] = pix.green;
        raw[2] = pix.blue;

        // Add the error carried from the left and from the row above, then
        // saturate. The line store is not looked at on the first row.
        for (k = 0; k < 3; k++)
        begin
            if (shadow_diffuse)
            begin
                val[k] = raw[k] + carry_right[k] + ((row_pos == 0) ? 0 : line_err[col][k]);
                if (val[k] < -256)
                begin
                    val[k] = -256;
                end
                if (val[k] > 511)
                begin
                    val[k] = 511;
                end
            end
            else
            begin
                val[k] = raw[k];
            end
        end

        // Least squared distance; only a strictly smaller one replaces the best,
        // so ties stay with the lower index.
        best      = 0;
        best_dist = 0;
        for (i = 0; i < n; i++)
        begin
            pix_dist = 0;
            for (k = 0; k < 3; k++)
            begin
                d = val[k] - int'(entry_rgb[i][k]);
                pix_dist += d * d;
            end
            if (i == 0 || pix_dist < best_dist)
            begin
                best_dist = pix_dist;
                best      = i;
            end
        end

        // Spread the error: 3/8 right, 3/8 down, 2/8 down-right, truncated toward
        // zero. The down-right part of the previous pixel joins this column's
        // down part. Nothing crosses the right edge.
        for (k = 0; k < 3; k++)
        begin
            e     = shadow_diffuse ? val[k] - int'(entry_rgb[best][k]) : 0;
            three = (e * 3) / 8;
            two   = (e * 2) / 8;
            line_err[col][k] = err_t'(three + carry_diag[k]);
            carry_right[k]   = last_col ? err_t'(0) : err_t'(three);
            carry_diag[k]    = last_col ? err_t'(0) : err_t'(two);
        end

        if (last_col)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos = col + 1;
        end

        res.out_red      = entry_rgb[best][0];
        res.out_green    = entry_rgb[best][1];
        res.out_blue     = entry_rgb[best][2];
        res.out_alpha    = pix.alpha;
        res.chosen_index = 8'(best);
        return res;
    endfunction

    // Channel level for random pixels: mostly anything, with the extremes boosted
    // so that saturation of the diffused value is reached often.
    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Offers one beat, with random idle cycles in front of it, and holds it until
    // the block takes it. On acceptance the predictor is updated; a pixel queues
    // its expected result, which is the row's own value when one is given.
    task automatic send_beat(in_item_t beat, bit use_known, out_item_t known);
        out_item_t predicted;
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= beat;
        do @(posedge clk); while (pix_stall);
        if (beat.op == OP_PIXEL)
        begin
            predicted = quantize_pixel(beat);
            quantized_due.push_back(use_known ? known : predicted);
        end
        else
        begin
            entry_rgb[beat.entry_index][0] = beat.red;
            entry_rgb[beat.entry_index][1] = beat.green;
            entry_rgb[beat.entry_index][2] = beat.blue;
        end
        beats_sent++;
    endtask

    // Stops offering beats until every outstanding result has come back, then
    // waits the given number of further cycles. The first clock edge is always
    // taken so that valid is never lowered and raised within one time step.
    task automatic settle(int extra);
        pix_valid <= 1'b0;
        @(posedge clk);
        while (quantized_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (extra) @(posedge clk);
    endtask

    // Writes one register and mirrors it in the shadow copy. Only called while
    // the block is idle.
    task automatic set_register(cfg_index_t sel, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (sel)
            CFG_IMAGE_WIDTH:
            begin
                shadow_width = value[IMG_WIDTH_W-1:0];
                restart_frame();
            end
            CFG_IMAGE_HEIGHT:
            begin
                shadow_height = value[IMG_HEIGHT_W-1:0];
                restart_frame();
            end
            CFG_PALETTE_COUNT:
            begin
                shadow_count = value[PAL_COUNT_W-1:0];
            end
            default:
            begin
                shadow_diffuse = value[0];
            end
        endcase
    endtask

    // Compares a result beat with the oldest expectation, field by field.
    task automatic check_result(out_item_t got);
        out_item_t want;
        if (quantized_due.size() == 0)
        begin
            $error("result beat with no pixel outstanding: %h", got);
            mismatch_count++;
            return;
        end
        want = quantized_due.pop_front();
        if (got.out_red !== want.out_red)
        begin
            $error("out_red expected %0d, got %0d", want.out_red, got.out_red);
            mismatch_count++;
        end
        if (got.out_green !== want.out_green)
        begin
            $error("out_green expected %0d, got %0d", want.out_green, got.out_green);
            mismatch_count++;
        end
        if (got.out_blue !== want.out_blue)
        begin
            $error("out_blue expected %0d, got %0d", want.out_blue, got.out_blue);
            mismatch_count++;
        end
        if (got.out_alpha !== want.out_alpha)
        begin
            $error("out_alpha expected %0d, got %0d", want.out_alpha, got.out_alpha);
            mismatch_count++;
        end
        if (got.chosen_index !== want.chosen_index)
        begin
            $error("chosen_index expected %0d, got %0d", want.chosen_index, got.chosen_index);
            mismatch_count++;
        end
    endtask

    // The receiver stalls at random, except during the steady stretch.
    always @(posedge clk)
    begin
        res_stall <= !steady_flow && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // A result beat is taken at every edge where valid is high and stall is low.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            check_result(res_data);
        end
    end

    initial
    begin : stimulus
        in_item_t              beat;
        plan_step_t            row;
        int                    step;
        int                    phase;
        int                    count;
        int                    i;
        bit                    after_reg;
        logic [CFG_DATA_W-1:0] width_val;
        logic [CFG_DATA_W-1:0] height_val;
        logic [CFG_DATA_W-1:0] count_val;
        logic [CFG_DATA_W-1:0] diffuse_val;
        bit                    write_all;

        foreach (line_err[i, k])
        begin
            line_err[i][k] = '0;
        end
        foreach (entry_rgb[i, k])
        begin
            entry_rgb[i][k] = '0;
        end
        restart_frame();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every entry is written before any pixel, so no search ever reads an
        // entry that was never written. The ramp makes the directed rows easy
        // to read.
        for (i = 0; i < PALETTE_DEPTH; i++)
        begin
            beat = '{OP_PALETTE, 8'(i), 8'(i), 8'(i), 8'(i), 8'($urandom_range(0, 255))};
            send_beat(beat, 1'b0, NO_RESULT);
        end

        // Directed rows. A run of register rows is preceded by one full drain.
        after_reg = 1'b0;
        for (step = 0; step < DIRECTED_STEPS; step++)
        begin
            row = DIRECTED_PLAN[step];
            case (row.kind)
                STEP_REG:
                begin
                    if (!after_reg)
                    begin
                        settle(DRAIN_CYCLES);
                    end
                    set_register(row.sel, row.value);
                end
                STEP_BEAT:  send_beat(row.beat, 1'b0, NO_RESULT);
                default:    send_beat(row.beat, 1'b1, row.known);
            endcase
            after_reg = (row.kind == STEP_REG);
        end

        // Random phases: each one drains the block, rewrites some registers and
        // then streams raster pixels with a few palette rewrites mixed in.
        beats_sent = 0;
        phase      = 0;
        while (beats_sent < RANDOM_BEATS)
        begin
            settle(DRAIN_CYCLES);
            steady_flow = (phase == 3 || phase == 4);

            case ($urandom_range(0, 9))
                0:       width_val = CFG_DATA_W'(1);
                1:       width_val = CFG_DATA_W'(2);
                2, 3, 4: width_val = CFG_DATA_W'($urandom_range(3, 8));
                5, 6:    width_val = CFG_DATA_W'($urandom_range(9, 40));
                7:       width_val = CFG_DATA_W'($urandom_range(0, 8191));
                8:       width_val = CFG_DATA_W'(MAX_WIDTH);
                default: width_val = CFG_DATA_W'(0);
            endcase
            case ($urandom_range(0, 7))
                0:       height_val = CFG_DATA_W'(1);
                1:       height_val = CFG_DATA_W'(0);
                2:       height_val = CFG_DATA_W'(8191);
                default: height_val = CFG_DATA_W'($urandom_range(2, 6));
            endcase
            case ($urandom_range(0, 9))
                0:       count_val = CFG_DATA_W'(1);
                1:       count_val = CFG_DATA_W'(0);
                2:       count_val = CFG_DATA_W'(511);
                3:       count_val = CFG_DATA_W'(PALETTE_DEPTH);
                4, 5:    count_val = CFG_DATA_W'($urandom_range(2, 8));
                6, 7:    count_val = CFG_DATA_W'($urandom_range(9, 40));
                8:       count_val = CFG_DATA_W'($urandom_range(41, 511));
                default: count_val = CFG_DATA_W'($urandom_range(2, 255));
            endcase
            // Upper bits of the enable are don't-care; bit 0 is on three times in four.
            diffuse_val = CFG_DATA_W'($urandom_range(0, 8191));
            diffuse_val[0] = ($urandom_range(0, 3) != 0);

            // The first two phases pin the widest frame; the second also pins the full palette.
            write_all = (phase < 2);
            if (phase == 0)
            begin
                width_val  = CFG_DATA_W'(MAX_WIDTH);
                height_val = CFG_DATA_W'(8191);
                count_val  = CFG_DATA_W'(2);
            end
            if (phase == 1)
            begin
                width_val  = CFG_DATA_W'(4095);
                height_val = CFG_DATA_W'(1);
                count_val  = CFG_DATA_W'(PALETTE_DEPTH);
            end

            // Skipped geometry writes let a frame run on across phases.
            if (write_all || $urandom_range(0, 9) < 7)
            begin
                set_register(CFG_IMAGE_WIDTH, width_val);
            end
            if (write_all || $urandom_range(0, 9) < 7)
            begin
                set_register(CFG_IMAGE_HEIGHT, height_val);
            end
            if (write_all || $urandom_range(0, 9) < 7)
            begin
                set_register(CFG_PALETTE_COUNT, count_val);
            end
            if (write_all || $urandom_range(0, 9) < 7)
            begin
                set_register(CFG_DIFFUSION_ENABLE, diffuse_val);
            end

            count = (phase == 0) ? 150 : ((phase == 1) ? 30 : $urandom_range(20, 100));
            repeat (count)
            begin
                if ($urandom_range(0, 99) < 8)
                begin
                    beat = '{OP_PALETTE, 8'($urandom_range(0, 255)), pick_level(),
                             pick_level(), pick_level(), 8'($urandom_range(0, 255))};
                end
                else
                begin
                    beat = '{OP_PIXEL, 8'($urandom_range(0, 255)), pick_level(),
                             pick_level(), pick_level(), 8'($urandom_range(0, 255))};
                end
                send_beat(beat, 1'b0, NO_RESULT);
                // Now and then the sender holds off until the block has caught up.
                if ($urandom_range(0, 99) < 2)
                begin
                    settle(0);
                end
            end
            phase++;
        end

        // Everything is in; wait for the last results and watch for stray beats.
        steady_flow = 1'b0;
        settle(DRAIN_CYCLES);
        if (mismatch_count == 0 && quantized_due.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
